### rtl/fvcu_pkg.sv
// ----------------------------------------------------------------------------
// fvcu_pkg
// Shared constants, types and arithmetic helpers of the cell velocity update.
// ----------------------------------------------------------------------------
package fvcu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int FACES_DEF     = 3;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VISCOSITY = 1'b1;

    // Datapath operation codes issued by the controller.
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_DOT1   = 4'd1;
    localparam logic [3:0] OP_DOT2   = 4'd2;
    localparam logic [3:0] OP_DOT3   = 4'd3;
    localparam logic [3:0] OP_VISC   = 4'd4;
    localparam logic [3:0] OP_CONV   = 4'd5;
    localparam logic [3:0] OP_LEN    = 4'd6;
    localparam logic [3:0] OP_ACC    = 4'd7;
    localparam logic [3:0] OP_DIVST  = 4'd8;
    localparam logic [3:0] OP_DIVIT  = 4'd9;
    localparam logic [3:0] OP_UPD1   = 4'd10;
    localparam logic [3:0] OP_UPD2   = 4'd11;
    localparam logic [3:0] OP_FIN    = 4'd12;
    localparam logic [3:0] OP_ZERO   = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic       load;
    } fvcu_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_face;
        logic area_zero;
    } fvcu_sts_t;

    // Floor shift of an exact product, saturated to 32 bits signed.
    function automatic logic [32:0] mulq_sat(input logic signed [63:0] p,
                                             input int fb);
        logic signed [63:0] s;
        logic               ov;
        logic [31:0]        r;
        begin
            s  = p >>> fb;
            ov = 1'b0;
            r  = s[31:0];
            if (s > 64'sd2147483647) begin
                r = 32'h7FFF_FFFF; ov = 1'b1;
            end else if (s < -64'sd2147483648) begin
                r = 32'h8000_0000; ov = 1'b1;
            end
            mulq_sat = {ov, r};
        end
    endfunction

    // Saturate a 35 bit signed sum to 32 bits.
    function automatic logic [32:0] sat32_35(input logic signed [34:0] s);
        logic [32:0] r;
        begin
            r = {1'b0, s[31:0]};
            if (s > 35'sd2147483647)       r = {1'b1, 32'h7FFF_FFFF};
            else if (s < -35'sd2147483648) r = {1'b1, 32'h8000_0000};
            sat32_35 = r;
        end
    endfunction

endpackage

### rtl/fvcu_if.sv
// ----------------------------------------------------------------------------
// fvcu_if
// Valid/ready channel interfaces for faces, results and configuration.
// ----------------------------------------------------------------------------
interface fvcu_face_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] face_vx;
    logic signed [31:0] face_vy;
    logic signed [31:0] grad_x_of_vx;
    logic signed [31:0] grad_y_of_vx;
    logic signed [31:0] grad_x_of_vy;
    logic signed [31:0] grad_y_of_vy;
    logic        [30:0] edge_length;
    logic        [30:0] cell_area;
    logic signed [31:0] old_vx;
    logic signed [31:0] old_vy;
    modport source (output valid, normal_x, normal_y, face_vx, face_vy, grad_x_of_vx,
                    grad_y_of_vx, grad_x_of_vy, grad_y_of_vy, edge_length, cell_area,
                    old_vx, old_vy, input ready);
    modport sink (input valid, normal_x, normal_y, face_vx, face_vy, grad_x_of_vx,
                  grad_y_of_vx, grad_x_of_vy, grad_y_of_vy, edge_length, cell_area,
                  old_vx, old_vy, output ready);
endinterface

interface fvcu_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_vx;
    logic signed [31:0] new_vy;
    logic               range_flag;
    modport source (output valid, new_vx, new_vy, range_flag, input ready);
    modport sink (input valid, new_vx, new_vy, range_flag, output ready);
endinterface

interface fvcu_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/fvcu_datapath.sv
// ----------------------------------------------------------------------------
// fvcu_datapath
// Shared 32x32 multipliers, accumulators, a restoring divider and the
// final update logic, all driven by controller commands.
// ----------------------------------------------------------------------------
module fvcu_datapath
    import fvcu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  fvcu_cmd_t          cmd,
    output fvcu_sts_t          sts,
    input  logic signed [31:0] normal_x,
    input  logic signed [31:0] normal_y,
    input  logic signed [31:0] face_vx,
    input  logic signed [31:0] face_vy,
    input  logic signed [31:0] grad_x_of_vx,
    input  logic signed [31:0] grad_y_of_vx,
    input  logic signed [31:0] grad_x_of_vy,
    input  logic signed [31:0] grad_y_of_vy,
    input  logic        [30:0] edge_length,
    input  logic        [30:0] cell_area,
    input  logic signed [31:0] old_vx,
    input  logic signed [31:0] old_vy,
    input  logic        [30:0] step_dt,
    input  logic        [30:0] viscosity,
    output logic signed [31:0] new_vx,
    output logic signed [31:0] new_vy,
    output logic               range_flag
);

    localparam int DIV_N = 31 + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_N + 1);
    localparam int SH    = 24 - FRAC_BITS;

    // Latched face operands.
    logic signed [31:0] nx_reg, ny_reg, vx_reg, vy_reg;
    logic signed [31:0] gxx_reg, gyx_reg, gxy_reg, gyy_reg;
    logic        [30:0] len_reg, area_reg;
    logic signed [31:0] ovx_reg, ovy_reg;

    // Intermediate results.
    logic signed [31:0] vn_reg, dnx_reg, dny_reg;
    logic signed [31:0] tx_reg, ty_reg, cx_reg, cy_reg;
    logic signed [31:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [47:0] sumx_reg, sumy_reg;
    logic [1:0]         face_reg;
    logic               sticky_reg;

    // Divider state.
    logic [DIV_N-1:0]   quo_reg;
    logic [30:0]        rem_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // Update magnitude.
    logic [33:0]        dx_reg, dy_reg;

    logic [31:0]        ratio;
    logic               ratio_ov;

    assign ratio_ov = |quo_reg[DIV_N-1:32];
    assign ratio    = ratio_ov ? 32'hFFFF_FFFF : quo_reg[31:0];

    // Saturated Q product of two signed operands.
    function automatic logic [32:0] qm(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
        logic signed [63:0] p;
        begin
            p  = 64'(a) * 64'(b);
            qm = mulq_sat(p, FRAC_BITS);
        end
    endfunction

    // Two-term dot product with saturations.
    function automatic logic [32:0] dot(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
        logic [32:0] p1, p2, s;
        begin
            p1  = qm(a, nx_reg);
            p2  = qm(b, ny_reg);
            s   = sat32_35(35'(signed'(p1[31:0])) + 35'(signed'(p2[31:0])));
            dot = {p1[32] | p2[32] | s[32], s[31:0]};
        end
    endfunction

    // Increment magnitude for one axis: (|sum| * ratio) >> FRAC_BITS, capped.
    function automatic logic [33:0] incr(input logic signed [47:0] sum,
                                         input logic [31:0] r);
        logic [47:0] mag;
        logic [23:0] hi_m;
        logic [63:0] hi, lo, d;
        begin
            mag  = sum[47] ? 48'(-sum) : 48'(sum);
            hi_m = mag[47:24];
            hi   = 64'(hi_m) * 64'(r);
            lo   = 64'(mag[23:0]) * 64'(r);
            if (hi > (64'd1 << (33 - SH))) d = 64'd1 << 33;
            else d = (hi << SH) + (lo >> FRAC_BITS);
            if (d > (64'd1 << 33)) d = 64'd1 << 33;
            incr = d[33:0];
        end
    endfunction

    // Accumulator update with 48 bit saturation.
    function automatic logic [48:0] acc(input logic signed [47:0] s,
                                        input logic signed [31:0] a,
                                        input logic signed [31:0] b);
        logic signed [49:0] t;
        logic [48:0]        r;
        begin
            t = 50'(s) + 50'(a) - 50'(b);
            r = {1'b0, t[47:0]};
            if (t > 50'sd140737488355327)       r = {1'b1, 48'h7FFF_FFFF_FFFF};
            else if (t < -50'sd140737488355328) r = {1'b1, 48'h8000_0000_0000};
            acc = r;
        end
    endfunction

    logic [32:0] d1, d2, d3, m1, m2, m3, m4;
    logic [48:0] ax_n, ay_n;
    logic [32:0] ux, uy;
    logic [31:0] trial;
    logic [32:0] diff;
    logic signed [31:0] nu;
    logic signed [31:0] lenq;
    logic               lenop;

    assign nu    = signed'({1'b0, viscosity});
    assign lenq  = signed'({1'b0, len_reg});
    assign lenop = (cmd.op == OP_LEN);
    assign d1 = dot(vx_reg, vy_reg);
    assign d2 = dot(gxx_reg, gyx_reg);
    assign d3 = dot(gxy_reg, gyy_reg);

    // The length step reuses the multipliers of the viscous and convective steps.
    assign m1 = qm(lenop ? tx_reg : nu, lenop ? lenq : dnx_reg);
    assign m2 = qm(lenop ? ty_reg : nu, lenop ? lenq : dny_reg);
    assign m3 = qm(lenop ? cx_reg : vn_reg, lenop ? lenq : vx_reg);
    assign m4 = qm(lenop ? cy_reg : vn_reg, lenop ? lenq : vy_reg);
    assign ax_n = acc(sumx_reg, ax_reg, bx_reg);
    assign ay_n = acc(sumy_reg, ay_reg, by_reg);

    // Restoring divider step: shift in the next dividend bit, then compare.
    assign trial = {rem_reg, quo_reg[DIV_N-1]};
    assign diff  = {1'b0, trial} - {2'b0, area_reg};
    assign ux = sat32_35(sumx_reg[47] ? 35'(ovx_reg) - 35'(dx_reg)
                                      : 35'(ovx_reg) + 35'(dx_reg));
    assign uy = sat32_35(sumy_reg[47] ? 35'(ovy_reg) - 35'(dy_reg)
                                      : 35'(ovy_reg) + 35'(dy_reg));

    assign sts.div_done  = (cnt_reg == CNT_W'(DIV_N));
    assign sts.last_face = (face_reg == 2'(FACES_DEF - 1));
    assign sts.area_zero = (area_reg == 31'd0);

    // Operand capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            nx_reg <= normal_x;  ny_reg <= normal_y;
            vx_reg <= face_vx;   vy_reg <= face_vy;
            gxx_reg <= grad_x_of_vx; gyx_reg <= grad_y_of_vx;
            gxy_reg <= grad_x_of_vy; gyy_reg <= grad_y_of_vy;
            len_reg <= edge_length;  area_reg <= cell_area;
            ovx_reg <= old_vx;   ovy_reg <= old_vy;
        end
    end

    // Sequenced arithmetic.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sumx_reg   <= '0;
            sumy_reg   <= '0;
            face_reg   <= '0;
            sticky_reg <= 1'b0;
            cnt_reg    <= '0;
            range_flag <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_DOT1:
                begin
                    vn_reg <= signed'(d1[31:0]);
                    sticky_reg <= sticky_reg | d1[32];
                end
                OP_DOT2:
                begin
                    dnx_reg <= signed'(d2[31:0]);
                    sticky_reg <= sticky_reg | d2[32];
                end
                OP_DOT3:
                begin
                    dny_reg <= signed'(d3[31:0]);
                    sticky_reg <= sticky_reg | d3[32];
                end
                OP_VISC:
                begin
                    tx_reg <= signed'(m1[31:0]);
                    ty_reg <= signed'(m2[31:0]);
                    sticky_reg <= sticky_reg | m1[32] | m2[32];
                end
                OP_CONV:
                begin
                    cx_reg <= signed'(m3[31:0]);
                    cy_reg <= signed'(m4[31:0]);
                    sticky_reg <= sticky_reg | m3[32] | m4[32];
                end
                OP_LEN:
                begin
                    ax_reg <= signed'(m1[31:0]);
                    ay_reg <= signed'(m2[31:0]);
                    bx_reg <= signed'(m3[31:0]);
                    by_reg <= signed'(m4[31:0]);
                    sticky_reg <= sticky_reg | m1[32] | m2[32] | m3[32] | m4[32];
                end
                OP_ACC:
                begin
                    sumx_reg <= signed'(ax_n[47:0]);
                    sumy_reg <= signed'(ay_n[47:0]);
                    sticky_reg <= sticky_reg | ax_n[48] | ay_n[48];
                    if (!sts.last_face) face_reg <= face_reg + 2'd1;
                end
                OP_DIVST:
                begin
                    quo_reg <= {step_dt, FRAC_BITS'(0)};
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                OP_DIVIT:
                begin
                    if (diff[32])
                    begin
                        rem_reg <= trial[30:0];
                        quo_reg <= {quo_reg[DIV_N-2:0], 1'b0};
                    end
                    else
                    begin
                        rem_reg <= diff[30:0];
                        quo_reg <= {quo_reg[DIV_N-2:0], 1'b1};
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                OP_UPD1:
                begin
                    dx_reg <= incr(sumx_reg, ratio);
                    dy_reg <= incr(sumy_reg, ratio);
                    sticky_reg <= sticky_reg | ratio_ov;
                end
                OP_UPD2:
                begin
                    new_vx <= signed'(ux[31:0]);
                    new_vy <= signed'(uy[31:0]);
                    range_flag <= sticky_reg | ux[32] | uy[32];
                    sumx_reg <= '0; sumy_reg <= '0;
                    face_reg <= '0; sticky_reg <= 1'b0;
                end
                OP_ZERO:
                begin
                    new_vx <= ovx_reg;
                    new_vy <= ovy_reg;
                    range_flag <= 1'b1;
                    sumx_reg <= '0; sumy_reg <= '0;
                    face_reg <= '0; sticky_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

endmodule

### rtl/fvcu_ctrl.sv
// ----------------------------------------------------------------------------
// fvcu_ctrl
// Controller that sequences one face through the datapath and hands the
// cell result to the output register.
// ----------------------------------------------------------------------------
module fvcu_ctrl
    import fvcu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output fvcu_cmd_t cmd,
    input  fvcu_sts_t sts
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_D1   = 4'd1;
    localparam logic [3:0] S_D2   = 4'd2;
    localparam logic [3:0] S_D3   = 4'd3;
    localparam logic [3:0] S_VISC = 4'd4;
    localparam logic [3:0] S_CONV = 4'd5;
    localparam logic [3:0] S_LEN  = 4'd6;
    localparam logic [3:0] S_ACC  = 4'd7;
    localparam logic [3:0] S_DST  = 4'd8;
    localparam logic [3:0] S_DIT  = 4'd9;
    localparam logic [3:0] S_U1   = 4'd10;
    localparam logic [3:0] S_U2   = 4'd11;
    localparam logic [3:0] S_ZERO = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       fin;
    logic       out_free;

    // A new face may enter whenever the sequencer is idle; a finished cell
    // waits in its last step until the output register is free.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_free  = !ovalid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.load   = 1'b0;
        fin        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid && in_ready;
                if (in_valid && in_ready) state_next = S_D1;
            end
            S_D1:   begin cmd.op = OP_DOT1; state_next = S_D2;   end
            S_D2:   begin cmd.op = OP_DOT2; state_next = S_D3;   end
            S_D3:   begin cmd.op = OP_DOT3; state_next = S_VISC; end
            S_VISC: begin cmd.op = OP_VISC; state_next = S_CONV; end
            S_CONV: begin cmd.op = OP_CONV; state_next = S_LEN;  end
            S_LEN:  begin cmd.op = OP_LEN;  state_next = S_ACC;  end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                if (!sts.last_face)     state_next = S_IDLE;
                else if (sts.area_zero) state_next = S_ZERO;
                else                    state_next = S_DST;
            end
            S_DST:  begin cmd.op = OP_DIVST; state_next = S_DIT; end
            S_DIT:
            begin
                if (sts.div_done) state_next = S_U1;
                else cmd.op = OP_DIVIT;
            end
            S_U1:   begin cmd.op = OP_UPD1; state_next = S_U2; end
            S_U2:
            begin
                if (out_free)
                begin
                    cmd.op = OP_UPD2; fin = 1'b1; state_next = S_IDLE;
                end
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    cmd.op = OP_ZERO; fin = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        ovalid_next = fin | (ovalid_reg & !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

### rtl/fv_cell_velocity_update.sv
// ----------------------------------------------------------------------------
// fv_cell_velocity_update
// Finite-volume velocity update of one triangular cell, one face per
// transaction, result on every third face.
// ----------------------------------------------------------------------------
// Each face is sequenced by the controller through the shared multiply steps
// from acceptance to the next ready. The third face of a cell adds a setup
// step, the restoring divider for the step over cell_area with one quotient
// bit per cycle, a done check and two update steps; with zero area it adds a
// single zero step instead. The last step of a third face waits while an
// earlier result is still held on the result channel.
module fv_cell_velocity_update
    import fvcu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    fvcu_face_if.sink    face,
    fvcu_result_if.source result,
    fvcu_cfg_if.sink     cfg
);

    logic [30:0] step_dt_reg;
    logic [30:0] viscosity_reg;
    fvcu_cmd_t   cmd;
    fvcu_sts_t   sts;

    // Configuration registers.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_dt_reg   <= 31'd655;
            viscosity_reg <= 31'd0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TIME_STEP: step_dt_reg   <= cfg.data[30:0];
                REG_VISCOSITY: viscosity_reg <= cfg.data[30:0];
                default: ;
            endcase
        end
    end

    fvcu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (face.valid),
        .in_ready  (face.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    fvcu_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .normal_x     (face.normal_x),
        .normal_y     (face.normal_y),
        .face_vx      (face.face_vx),
        .face_vy      (face.face_vy),
        .grad_x_of_vx (face.grad_x_of_vx),
        .grad_y_of_vx (face.grad_y_of_vx),
        .grad_x_of_vy (face.grad_x_of_vy),
        .grad_y_of_vy (face.grad_y_of_vy),
        .edge_length  (face.edge_length),
        .cell_area    (face.cell_area),
        .old_vx       (face.old_vx),
        .old_vy       (face.old_vy),
        .step_dt      (step_dt_reg),
        .viscosity    (viscosity_reg),
        .new_vx       (result.new_vx),
        .new_vy       (result.new_vy),
        .range_flag   (result.range_flag)
    );

endmodule
